// ===== hw/rtl/calendar_minutes_adder_core_assert.svh =====
// Assertion helpers, clocked with reset disable.
`ifndef CALENDAR_MINUTES_ADDER_CORE_ASSERT_SVH
`define CALENDAR_MINUTES_ADDER_CORE_ASSERT_SVH

// same-cycle implication
`define CMA_ASSERT_IMP(lbl, ck, rs, a, b, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define CMA_ASSERT_NXT(lbl, ck, rs, a, b, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) else $error(msg);

`endif

// ===== hw/rtl/cma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

  localparam int IN_W  = 64;
  localparam int OUT_W = 48;

  // floor(x / d) = (x * RECIP) >> SHIFT, exact over the value ranges used here
  localparam logic [16:0] RECIP60  = 17'd69906;
  localparam logic [11:0] RECIP24  = 12'd2731;
  localparam logic [5:0]  RECIP7   = 6'd37;
  localparam logic [15:0] RECIP400 = 16'd41944;

  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;
  localparam logic [14:0] YEAR_LIMIT = 15'd9999;
  localparam logic [14:0] YEAR_WRAP  = 15'd10000;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_Q60,
    CMD_R60,
    CMD_Q24,
    CMD_R24,
    CMD_LEAPQ,
    CMD_STEP,
    CMD_FIN
  } cmd_t;

  typedef struct packed {
    logic fit;
  } status_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cma_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cma_dpath import cma_pkg::*; (
  input  wire logic             clk,
  input  wire cmd_t             cmd,
  input  wire logic [IN_W-1:0]  s_tdata,
  output status_t               status,
  output logic [OUT_W-1:0]      m_tdata
);

  logic [14:0] year;
  logic [3:0]  month;
  logic [6:0]  day;
  logic [2:0]  wday;
  logic [4:0]  hour;
  logic [5:0]  mins;
  logic [5:0]  sec;
  logic [16:0] total;
  logic [10:0] q60;
  logic [10:0] hours;
  logic [5:0]  dadd;
  logic [5:0]  q400;

  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [33:0] prod60;
  logic [16:0] rem60;
  logic [22:0] prod24;
  logic [10:0] rem24;
  logic [5:0]  wsum;
  logic [11:0] prod7;
  logic [5:0]  rem7;
  logic [30:0] prod400;
  logic [14:0] r400;
  logic [8:0]  r400s;
  logic [8:0]  r100;
  logic        leap;
  logic [4:0]  len;
  logic        fit;
  logic [14:0] year_fin;

  assign in_month = s_tdata[17:14];
  assign in_day   = s_tdata[22:18];

  assign prod60 = 34'(total) * 34'(RECIP60);
  assign rem60  = total - ({6'd0, q60} * 17'd60);
  assign prod24 = 23'(hours) * 23'(RECIP24);
  assign rem24  = hours - ({5'd0, dadd} * 11'd24);
  assign wsum   = {3'd0, wday} + 6'd6 + dadd;
  assign prod7  = 12'(wsum) * 12'(RECIP7);
  assign rem7   = wsum - ({2'd0, prod7[11:8]} * 6'd7);

  assign prod400 = 31'(year) * 31'(RECIP400);
  assign r400    = year - ({9'd0, q400} * 15'd400);
  assign r400s   = r400[8:0];

  always_comb begin
    if (r400s >= 9'd300) begin
      r100 = r400s - 9'd300;
    end else if (r400s >= 9'd200) begin
      r100 = r400s - 9'd200;
    end else if (r400s >= 9'd100) begin
      r100 = r400s - 9'd100;
    end else begin
      r100 = r400s;
    end
  end

  assign leap = ((year[1:0] == 2'd0) && (r100 != 9'd0)) || (r400 == 15'd0);
  assign len  = month_days(month, leap);
  assign fit  = (day <= {2'd0, len});
  assign status.fit = fit;

  assign year_fin = (year > YEAR_LIMIT) ? (year - YEAR_WRAP) : year;

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        year  <= {1'b0, s_tdata[13:0]};
        if (in_month == 4'd0) begin
          month <= MONTH_JAN;
        end else if (in_month > MONTH_DEC) begin
          month <= MONTH_DEC;
        end else begin
          month <= in_month;
        end
        day   <= (in_day == 5'd0) ? 7'd1 : {2'd0, in_day};
        wday  <= s_tdata[25:23];
        hour  <= s_tdata[30:26];
        sec   <= s_tdata[42:37];
        total <= {11'd0, s_tdata[36:31]} + {1'b0, s_tdata[58:43]};
      end
      CMD_Q60: begin
        q60 <= prod60[32:22];
      end
      CMD_R60: begin
        mins  <= rem60[5:0];
        hours <= {6'd0, hour} + q60;
      end
      CMD_Q24: begin
        dadd <= prod24[21:16];
      end
      CMD_R24: begin
        hour <= rem24[4:0];
        day  <= day + {1'b0, dadd};
        wday <= rem7[2:0] + 3'd1;
      end
      CMD_LEAPQ: begin
        q400 <= prod400[29:24];
      end
      CMD_STEP: begin
        if (!fit) begin
          day <= day - {2'd0, len};
          if (month == MONTH_DEC) begin
            month <= MONTH_JAN;
            year  <= year + 15'd1;
          end else begin
            month <= month + 4'd1;
          end
        end
      end
      CMD_FIN: begin
        m_tdata <= {4'd0, (year > YEAR_LIMIT), sec, mins, hour, wday,
                    day[4:0], month, year_fin[13:0]};
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cma_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cma_ctrl import cma_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_Q60,
    S_R60,
    S_Q24,
    S_R24,
    S_LEAPQ,
    S_STEP,
    S_FIN
  } state_t;

  state_t     state;
  logic [3:0] guard;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (state)
      S_IDLE:  cmd = s_tvalid ? CMD_LOAD : CMD_NONE;
      S_Q60:   cmd = CMD_Q60;
      S_R60:   cmd = CMD_R60;
      S_Q24:   cmd = CMD_Q24;
      S_R24:   cmd = CMD_R24;
      S_LEAPQ: cmd = CMD_LEAPQ;
      S_STEP:  cmd = CMD_STEP;
      S_FIN:   cmd = out_free ? CMD_FIN : CMD_NONE;
      default: cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      guard    <= 4'd0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_Q60;
          end
        end
        S_Q60:   state <= S_R60;
        S_R60:   state <= S_Q24;
        S_Q24:   state <= S_R24;
        S_R24: begin
          guard <= 4'd0;
          state <= S_LEAPQ;
        end
        S_LEAPQ: state <= S_STEP;
        S_STEP: begin
          // at most sixteen month carries
          if (status.fit || (guard == 4'd15)) begin
            state <= S_FIN;
          end else begin
            guard <= guard + 4'd1;
            state <= S_LEAPQ;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_minutes_adder_core.sv =====
// Month carries: N per word, 0..2 for any input; each carry is one reciprocal multiply plus
//   one check step.
// Input: the next word is taken once the result sits in the output register, which holds
//   it until m_tready.
// Reset: rst synchronous, active high; returns the sequencer to idle and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_minutes_adder_core_assert.svh"

module calendar_minutes_adder_core import cma_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // year_in[13:0], month_in[17:14], day_in[22:18], weekday_in[25:23], hour_in[30:26],
  // minute_in[36:31], second_in[42:37], minutes_to_add[58:43], zero[63:59]
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // year_out[13:0], month_out[17:14], day_out[22:18], weekday_out[25:23], hour_out[30:26],
  // minute_out[36:31], second_out[42:37], year_overflow[43], zero[47:44]
  output logic [OUT_W-1:0]      m_tdata
);

  cmd_t    cmd;
  status_t status;
  logic    in_take;
  logic    time_ok;
  logic    date_ok;

  cma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cma_dpath u_dpath (
    .clk     (clk),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .status  (status),
    .m_tdata (m_tdata)
  );

  assign in_take = s_tvalid && s_tready;
  assign time_ok = (m_tdata[30:26] < 5'd24) && (m_tdata[36:31] < 6'd60);
  assign date_ok = (m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= MONTH_DEC) &&
                   (m_tdata[25:23] != 3'd0) && (m_tdata[13:0] <= 14'd9999);

  `CMA_ASSERT_NXT(a_busy_after_accept, clk, rst, in_take, !s_tready, "input taken while busy")
  `CMA_ASSERT_NXT(a_fin_shows_result, clk, rst, cmd == CMD_FIN, m_tvalid, "result not presented")
  `CMA_ASSERT_IMP(a_time_range, clk, rst, m_tvalid, time_ok, "hour or minute out of range")
  `CMA_ASSERT_IMP(a_date_range, clk, rst, m_tvalid, date_ok, "date field out of range")

endmodule

`default_nettype wire
